FILE: rtl/assert_macros.svh
// Assertion macros used by the top level of the perceptron block.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("forbidden state");
`else
`define ASSERT_CLK(name, clk, rst, prop)
`define ASSERT_NEVER(name, clk, rst, cond)
`endif
`endif

FILE: rtl/mlp_pkg.sv
// Types and constants of the perceptron inference block.
// Used by the cell, the arithmetic unit and the top level.
package mlp_pkg;

  localparam int IDX_W = 10;
  localparam int BIAS_WORDS = 1024;
  localparam int BIAS_AW = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W = 9;
  localparam logic [63:0] EXP_STEP_Q30 = 64'd1040706261;

  localparam logic [2:0] MODE_WEIGHT = 3'd0;
  localparam logic [2:0] MODE_BIAS = 3'd1;
  localparam logic [2:0] MODE_MEAN = 3'd2;
  localparam logic [2:0] MODE_SCALE = 3'd3;
  localparam logic [2:0] MODE_OBS = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_LAYERS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OBS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_H1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_H2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_H3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACT = 3'd5;

  typedef struct packed {
    logic [2:0] mode;
    logic [15:0] address;
    logic signed [15:0] value;
  } in_t;

  typedef struct packed {
    logic [5:0] action_index;
    logic signed [15:0] action_value;
    logic last_action;
  } out_t;

  typedef struct packed {
    logic valid;
    logic norm;
    logic first;
    logic last;
    logic elu;
    logic to_ping;
    logic from_ping;
    logic [IDX_W-1:0] idx;
  } tag_t;

  typedef struct packed {
    logic en;
    logic to_ping;
    logic [IDX_W-1:0] idx;
    logic signed [15:0] data;
  } wr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_LAYER,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_t;

endpackage

FILE: rtl/mlp_cell.sv
// One cell of the control chain: registers the request tag.
// Depends on mlp_pkg.
module mlp_cell
  import mlp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  tag_t d,
  output tag_t q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else begin
      q <= d;
    end
  end

endmodule

FILE: rtl/mlp_mac.sv
// Multiply, accumulate, round, saturate and ELU stages of the datapath.
// Depends on mlp_pkg; stage tags come from the cell chain in the top level.
module mlp_mac
  import mlp_pkg::*;
#(
  parameter int ACC_W = 42,
  parameter int ELU_TABLE_DEPTH = 256
) (
  input  logic clk,
  input  tag_t t1,
  input  tag_t t2,
  input  tag_t t3,
  input  tag_t t4,
  input  logic signed [15:0] w_rd,
  input  logic signed [15:0] ping_rd,
  input  logic signed [15:0] pong_rd,
  input  logic signed [15:0] mean_rd,
  input  logic signed [15:0] scale_rd,
  input  logic signed [15:0] bias_rd,
  output wr_t wr
);

  localparam int EW = (ELU_TABLE_DEPTH > 1) ? $clog2(ELU_TABLE_DEPTH) : 1;
  typedef logic signed [15:0] rom_t [ELU_TABLE_DEPTH];

  function automatic rom_t build_rom();
    rom_t t;
    logic [63:0] p;
    p = 64'd1 << 30;
    for (int k = 0; k < ELU_TABLE_DEPTH; k++) begin
      t[k] = 16'(((p + (64'd1 << 17)) >> 18) - 64'd4096);
      p = ((p * EXP_STEP_Q30) + (64'd1 << 29)) >> 30;
    end
    return t;
  endfunction

  localparam rom_t ELU_ROM = build_rom();

  logic signed [16:0] op_a;
  logic signed [15:0] op_b;
  logic signed [32:0] prod;
  logic signed [15:0] bias_q;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-13:0] quo;
  logic signed [15:0] r;
  logic signed [16:0] neg_r;
  logic [16:0] elu_idx;
  logic signed [15:0] elu_val;

  always_comb begin
    if (t1.norm) begin
      op_a = {pong_rd[15], pong_rd} - {mean_rd[15], mean_rd};
      op_b = scale_rd;
    end else begin
      op_a = {w_rd[15], w_rd};
      op_b = t1.from_ping ? ping_rd : pong_rd;
    end
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    bias_q <= t1.norm ? 16'sd0 : bias_rd;
  end

  always_ff @(posedge clk) begin
    if (t2.valid) begin
      acc <= (t2.first ? (ACC_W'(bias_q) <<< 12) : acc) + ACC_W'(prod);
    end
  end

  always_comb begin
    rnd = acc + ACC_W'(2048);
    quo = (ACC_W-12)'(rnd >>> 12);
  end

  always_ff @(posedge clk) begin
    if (t3.valid) begin
      if (quo > (ACC_W-12)'(32767)) begin
        r <= 16'sh7fff;
      end else if (quo < -(ACC_W-12)'(32768)) begin
        r <= -16'sh8000;
      end else begin
        r <= 16'(quo);
      end
    end
  end

  always_comb begin
    neg_r = -{r[15], r};
    elu_idx = (17'(neg_r) + 17'd64) >> 7;
    if (r > 16'sd0) begin
      elu_val = r;
    end else if (32'(elu_idx) >= ELU_TABLE_DEPTH) begin
      elu_val = -16'sd4096;
    end else begin
      elu_val = ELU_ROM[elu_idx[EW-1:0]];
    end
    wr.en = t4.valid && t4.last;
    wr.to_ping = t4.to_ping;
    wr.idx = t4.idx;
    wr.data = t4.elu ? elu_val : r;
  end

endmodule

FILE: rtl/mlp_policy_inference_elu.sv
// Top level of the perceptron inference block: stores, sequencer, cell chain.
// Depends on mlp_pkg, mlp_cell, mlp_mac and assert_macros.svh.
//
//  channel  signals                                    direction
//  in       in_valid, in_ready, in_data                load word or observation element
//  out      out_valid, out_ready, out_data             n_act actions per pass
//  cfg      cfg_valid, cfg_ready, cfg_index, cfg_data  register write, always ready
//
// In idle every load request is accepted. The last observation element starts a pass:
// normalization of each element and n_in*n_out products per layer, each followed
// by a drain of the pipeline, then the actions one by one; the single multiplier and
// the one weight memory port pace the products. The input is held off from the
// start of a pass until its last action is taken. Stalls on out hold the pass.
// Reset is synchronous and needs no clearing pass.
module mlp_policy_inference_elu
  import mlp_pkg::*;
#(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_LAYERS = 4,
  parameter int WEIGHT_WORDS = 65536,
  parameter int MAX_ACTIONS = 64,
  parameter int ELU_TABLE_DEPTH = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

`include "assert_macros.svh"

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int LW = $clog2(MAX_LAYERS + 1);
  localparam int WAW = $clog2(WEIGHT_WORDS);
  localparam int ACC_W = 34 + $clog2(MAX_WIDTH);

  logic [2:0] reg_layers;
  logic [8:0] reg_obs;
  logic [8:0] reg_h1;
  logic [8:0] reg_h2;
  logic [8:0] reg_h3;
  logic [6:0] reg_act;

  state_t state;
  state_t state_next;

  logic [CW-1:0] i;
  logic [CW-1:0] o;
  logic [CW-1:0] n_in;
  logic [LW-1:0] layer;
  logic [WAW-1:0] waddr;
  logic [BIAS_AW-1:0] baddr;
  logic src_ping;
  logic in_norm;

  logic [CW-1:0] n_obs;
  logic [CW-1:0] n_h1;
  logic [CW-1:0] n_h2;
  logic [CW-1:0] n_h3;
  logic [CW-1:0] n_act;
  logic [LW-1:0] n_layers;
  logic [CW-1:0] n_out_cur;
  logic last_layer;
  logic in_acc;
  logic obs_ok;
  logic busy;
  logic out_last;

  tag_t taps [0:4];
  wr_t wr;

  logic signed [15:0] w_mem [WEIGHT_WORDS];
  logic signed [15:0] b_mem [BIAS_WORDS];
  logic signed [15:0] mean_mem [MAX_WIDTH];
  logic signed [15:0] scale_mem [MAX_WIDTH];
  logic signed [15:0] ping_mem [MAX_WIDTH];
  logic signed [15:0] pong_mem [MAX_WIDTH];
  logic signed [15:0] w_rd;
  logic signed [15:0] b_rd;
  logic signed [15:0] mean_rd;
  logic signed [15:0] scale_rd;
  logic signed [15:0] ping_rd;
  logic signed [15:0] pong_rd;

  function automatic logic [31:0] clamp(input logic [31:0] v, input logic [31:0] hi);
    logic [31:0] res;
    if (v == 32'd0) begin
      res = 32'd1;
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

  assign n_obs = CW'(clamp(32'(reg_obs), MAX_WIDTH));
  assign n_h1 = CW'(clamp(32'(reg_h1), MAX_WIDTH));
  assign n_h2 = CW'(clamp(32'(reg_h2), MAX_WIDTH));
  assign n_h3 = CW'(clamp(32'(reg_h3), MAX_WIDTH));
  assign n_act = CW'(clamp(clamp(32'(reg_act), MAX_ACTIONS), MAX_WIDTH));
  assign n_layers = LW'(clamp(32'(reg_layers), MAX_LAYERS));
  assign last_layer = (layer == n_layers - 1'b1);

  always_comb begin
    if (last_layer) begin
      n_out_cur = n_act;
    end else if (layer == LW'(0)) begin
      n_out_cur = n_h1;
    end else if (layer == LW'(1)) begin
      n_out_cur = n_h2;
    end else begin
      n_out_cur = n_h3;
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_layers <= 3'd4;
      reg_obs <= 9'd64;
      reg_h1 <= 9'd256;
      reg_h2 <= 9'd256;
      reg_h3 <= 9'd256;
      reg_act <= 7'd24;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LAYERS: reg_layers <= cfg_data[2:0];
        REG_OBS: reg_obs <= cfg_data;
        REG_H1: reg_h1 <= cfg_data;
        REG_H2: reg_h2 <= cfg_data;
        REG_H3: reg_h3 <= cfg_data;
        REG_ACT: reg_act <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign in_acc = in_valid && in_ready;
  assign obs_ok = (in_data.mode == MODE_OBS) && (32'(in_data.address) < 32'(n_obs));
  assign busy = taps[1].valid || taps[2].valid || taps[3].valid || taps[4].valid;
  assign out_last = (i == n_act - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    taps[0] = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_acc && obs_ok && (32'(in_data.address) + 32'd1 == 32'(n_obs))) begin
          state_next = ST_NORM;
        end
      end
      ST_NORM: begin
        taps[0].valid = 1'b1;
        taps[0].norm = 1'b1;
        taps[0].first = 1'b1;
        taps[0].last = 1'b1;
        taps[0].to_ping = 1'b1;
        taps[0].idx = IDX_W'(i);
        if (i == n_obs - 1'b1) begin
          state_next = ST_DRAIN;
        end
      end
      ST_LAYER: begin
        taps[0].valid = 1'b1;
        taps[0].first = (i == CW'(0));
        taps[0].last = (i == n_in - 1'b1);
        taps[0].elu = !last_layer;
        taps[0].to_ping = !src_ping;
        taps[0].from_ping = src_ping;
        taps[0].idx = IDX_W'(o);
        if ((i == n_in - 1'b1) && (o == n_out_cur - 1'b1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!busy) begin
          if (in_norm || !last_layer) begin
            state_next = ST_LAYER;
          end else begin
            state_next = ST_EMIT_RD;
          end
        end
      end
      ST_EMIT_RD: state_next = ST_EMIT_LD;
      ST_EMIT_LD: state_next = ST_EMIT_WAIT;
      ST_EMIT_WAIT: begin
        if (out_ready) begin
          state_next = out_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_norm <= 1'b0;
      src_ping <= 1'b0;
      layer <= '0;
      i <= '0;
      o <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          i <= '0;
          o <= '0;
          n_in <= n_obs;
          in_norm <= 1'b1;
          waddr <= '0;
          baddr <= '0;
        end
        ST_NORM: i <= i + 1'b1;
        ST_LAYER: begin
          waddr <= (waddr == WAW'(WEIGHT_WORDS - 1)) ? '0 : waddr + 1'b1;
          if (i == n_in - 1'b1) begin
            i <= '0;
            o <= o + 1'b1;
            baddr <= baddr + 1'b1;
          end else begin
            i <= i + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!busy) begin
            i <= '0;
            o <= '0;
            if (in_norm) begin
              in_norm <= 1'b0;
              layer <= '0;
              src_ping <= 1'b1;
            end else begin
              src_ping <= !src_ping;
              if (!last_layer) begin
                layer <= layer + 1'b1;
                n_in <= n_out_cur;
              end
            end
          end
        end
        ST_EMIT_WAIT: begin
          if (out_ready && !out_last) begin
            i <= i + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT_LD) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT_LD) begin
      out_data.action_index <= i[5:0];
      out_data.action_value <= src_ping ? ping_rd : pong_rd;
      out_data.last_action <= out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_data.mode == MODE_WEIGHT) && (32'(in_data.address) < WEIGHT_WORDS)) begin
      w_mem[WAW'(in_data.address)] <= in_data.value;
    end
    w_rd <= w_mem[waddr];
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_data.mode == MODE_BIAS) && (32'(in_data.address) < BIAS_WORDS)) begin
      b_mem[BIAS_AW'(in_data.address)] <= in_data.value;
    end
    b_rd <= b_mem[baddr];
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_data.mode == MODE_MEAN) && (32'(in_data.address) < MAX_WIDTH)) begin
      mean_mem[AW'(in_data.address)] <= in_data.value;
    end
    mean_rd <= mean_mem[i[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_data.mode == MODE_SCALE) && (32'(in_data.address) < MAX_WIDTH)) begin
      scale_mem[AW'(in_data.address)] <= in_data.value;
    end
    scale_rd <= scale_mem[i[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.to_ping) begin
      ping_mem[wr.idx[AW-1:0]] <= wr.data;
    end
    ping_rd <= ping_mem[i[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (in_acc && obs_ok) begin
      pong_mem[AW'(in_data.address)] <= in_data.value;
    end else if (wr.en && !wr.to_ping) begin
      pong_mem[wr.idx[AW-1:0]] <= wr.data;
    end
    pong_rd <= pong_mem[i[AW-1:0]];
  end

  for (genvar k = 1; k <= 4; k++) begin : g_chain
    mlp_cell u_cell (
      .clk(clk),
      .rst(rst),
      .d(taps[k-1]),
      .q(taps[k])
    );
  end

  mlp_mac #(
    .ACC_W(ACC_W),
    .ELU_TABLE_DEPTH(ELU_TABLE_DEPTH)
  ) u_mac (
    .clk(clk),
    .t1(taps[1]),
    .t2(taps[2]),
    .t3(taps[3]),
    .t4(taps[4]),
    .w_rd(w_rd),
    .ping_rd(ping_rd),
    .pong_rd(pong_rd),
    .mean_rd(mean_rd),
    .scale_rd(scale_rd),
    .bias_rd(b_rd),
    .wr(wr)
  );

  `ASSERT_CLK(a_out_state, clk, rst, out_valid |-> (state == ST_EMIT_WAIT))
  `ASSERT_NEVER(a_idle_quiet, clk, rst, in_ready && busy)
  `ASSERT_CLK(a_last_idle, clk, rst, (out_valid && out_ready && out_data.last_action) |=> in_ready)

endmodule

FILE: tb/tb_mlp_policy_inference_elu.sv
// Self-checking testbench for the perceptron inference block mlp_policy_inference_elu.
// Loads stores, writes registers, sends observation vectors and checks every action.
// Depends on mlp_pkg and the RTL of the block.
module tb_mlp_policy_inference_elu;
  import mlp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 2000000;

  class action_scoreboard;
    logic signed [15:0] weights[65536];
    logic signed [15:0] biases[1024];
    logic signed [15:0] means[256];
    logic signed [15:0] scales[256];
    logic signed [15:0] ping[256];
    logic signed [15:0] pong[256];
    logic signed [15:0] elu_tab[256];
    int unsigned n_layers, n_obs, h1, h2, h3, n_act;
    out_t expected_actions[$];
    int errors;

    function new();
      longint unsigned p;
      p = 64'd1 << 30;
      for (int k = 0; k < 256; k++) begin
        elu_tab[k] = 16'(((p + (64'd1 << 17)) >> 18) - 4096);
        p = (p * EXP_STEP_Q30 + (64'd1 << 29)) >> 30;
      end
      foreach (ping[i]) begin
        ping[i] = '0;
        pong[i] = '0;
      end
      n_layers = 4;
      n_obs = 64;
      h1 = 256;
      h2 = 256;
      h3 = 256;
      n_act = 24;
      errors = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
    endfunction

    function logic signed [15:0] round_sat(longint v);
      longint q;
      q = (v + 2048) >>> 12;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return 16'(q);
    endfunction

    function logic signed [15:0] elu(logic signed [15:0] x);
      int unsigned idx;
      if (x > 0) return x;
      idx = (int'(-int'(x)) + 64) >> 7;
      if (idx >= 256) return -16'sd4096;
      return elu_tab[idx];
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_LAYERS: n_layers = data[2:0];
        REG_OBS: n_obs = data;
        REG_H1: h1 = data;
        REG_H2: h2 = data;
        REG_H3: h3 = data;
        REG_ACT: n_act = data[6:0];
        default: ;
      endcase
    endfunction

    function void forward_pass();
      int unsigned layers, n_in, acts, n_out, woff, boff;
      bit src_ping, last;
      longint acc;
      logic signed [15:0] res[256];
      logic signed [15:0] s;
      out_t a;
      layers = clamp(n_layers, 4);
      n_in = clamp(n_obs, 256);
      acts = clamp(clamp(n_act, 64), 256);
      woff = 0;
      boff = 0;
      src_ping = 1;
      for (int i = 0; i < n_in; i++)
        ping[i] = round_sat((longint'(pong[i]) - longint'(means[i])) * longint'(scales[i]));
      for (int l = 0; l < layers; l++) begin
        last = (l + 1 == layers);
        if (last) n_out = acts;
        else if (l == 0) n_out = clamp(h1, 256);
        else if (l == 1) n_out = clamp(h2, 256);
        else n_out = clamp(h3, 256);
        for (int o = 0; o < n_out; o++) begin
          acc = longint'(biases[(boff + o) % 1024]) * 4096;
          for (int i = 0; i < n_in; i++) begin
            s = src_ping ? ping[i] : pong[i];
            acc += longint'(weights[(woff + o * n_in + i) % 65536]) * longint'(s);
          end
          res[o] = last ? round_sat(acc) : elu(round_sat(acc));
        end
        for (int o = 0; o < n_out; o++) begin
          if (src_ping) pong[o] = res[o];
          else ping[o] = res[o];
        end
        woff = (woff + n_in * n_out) % 65536;
        boff = (boff + n_out) % 1024;
        n_in = n_out;
        src_ping = !src_ping;
      end
      for (int i = 0; i < acts; i++) begin
        a.action_index = 6'(i);
        a.action_value = src_ping ? ping[i] : pong[i];
        a.last_action = (i + 1 == acts);
        expected_actions.push_back(a);
      end
    endfunction

    function void note_request(in_t req);
      int unsigned lim;
      case (req.mode)
        MODE_WEIGHT: weights[req.address] = req.value;
        MODE_BIAS: if (req.address < 1024) biases[req.address] = req.value;
        MODE_MEAN: if (req.address < 256) means[req.address] = req.value;
        MODE_SCALE: if (req.address < 256) scales[req.address] = req.value;
        MODE_OBS: begin
          lim = clamp(n_obs, 256);
          if (req.address < lim) begin
            pong[req.address] = req.value;
            if (req.address + 1 == lim) forward_pass();
          end
        end
        default: ;
      endcase
    endfunction

    function void check_action(out_t got);
      out_t exp_a;
      if (expected_actions.size() == 0) begin
        $error("action with nothing expected: index %0d value %0d",
               got.action_index, got.action_value);
        errors++;
        return;
      end
      exp_a = expected_actions.pop_front();
      if (got.action_index !== exp_a.action_index) begin
        $error("action_index expected %0d got %0d", exp_a.action_index, got.action_index);
        errors++;
      end
      if (got.action_value !== exp_a.action_value) begin
        $error("action_value expected %0d got %0d", exp_a.action_value, got.action_value);
        errors++;
      end
      if (got.last_action !== exp_a.last_action) begin
        $error("last_action expected %0d got %0d", exp_a.last_action, got.last_action);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  action_scoreboard sb = new();
  bit no_idle = 0;
  bit hold_req = 0;
  longint cycles = 0;

  mlp_policy_inference_elu dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_request(in_data);
    if (!rst && out_valid && out_ready) sb.check_action(out_data);
  end

  function int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function logic signed [15:0] pick_value();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 4095)) - 16'sd2048;
  endfunction

  initial begin
    int unsigned r;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else begin
        r = $urandom_range(0, 99);
        if (no_idle || r >= 25) begin
          out_ready <= 1'b1;
        end else if (r < 3) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(20, 60)) @(posedge clk);
        end else begin
          out_ready <= 1'b0;
        end
      end
    end
  end

  task automatic send_request(logic [2:0] mode, logic [15:0] address, logic signed [15:0] value);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data <= '{mode: mode, address: address, value: value};
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
    sb.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_actions.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_vector(int unsigned n);
    for (int i = 0; i < n; i++) send_request(MODE_OBS, 16'(i), pick_value());
  endtask

  task automatic run_phase(int unsigned layers, int unsigned obs, int unsigned w1, int unsigned w2,
                           int unsigned w3, int unsigned acts, int unsigned vectors);
    int unsigned nl, n_in, n_out, wtot, btot, nobs;
    wait_drained();
    write_reg(REG_LAYERS, 9'(layers));
    write_reg(REG_OBS, 9'(obs));
    write_reg(REG_H1, 9'(w1));
    write_reg(REG_H2, 9'(w2));
    write_reg(REG_H3, 9'(w3));
    write_reg(REG_ACT, 9'(acts));
    nl = sb.clamp(sb.n_layers, 4);
    nobs = sb.clamp(sb.n_obs, 256);
    n_in = nobs;
    wtot = 0;
    btot = 0;
    for (int l = 0; l < nl; l++) begin
      if (l + 1 == nl) n_out = sb.clamp(sb.n_act, 64);
      else if (l == 0) n_out = sb.clamp(sb.h1, 256);
      else if (l == 1) n_out = sb.clamp(sb.h2, 256);
      else n_out = sb.clamp(sb.h3, 256);
      wtot += n_in * n_out;
      btot += n_out;
      n_in = n_out;
    end
    for (int i = 0; i < wtot; i++) send_request(MODE_WEIGHT, 16'(i), pick_value());
    for (int i = 0; i < btot; i++) send_request(MODE_BIAS, 16'(i), pick_value());
    for (int i = 0; i < nobs; i++) begin
      send_request(MODE_MEAN, 16'(i), pick_value());
      send_request(MODE_SCALE, 16'(i), pick_value());
    end
    send_vector(nobs);
    for (int v = 1; v < vectors; v++) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: send_request(3'($urandom_range(5, 7)), 16'($urandom), 16'($urandom));
          1: send_request(MODE_OBS, 16'($urandom_range(nobs, 65535)), 16'($urandom));
          2: send_request(MODE_WEIGHT, 16'($urandom_range(0, wtot - 1)), pick_value());
          default: send_request(MODE_OBS, 16'($urandom_range(0, nobs - 1)), pick_value());
        endcase
      end
      send_vector(nobs);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_phase(2, 2, 2, 0, 0, 3, 1);
    send_request(MODE_OBS, 16'd0, 16'sh7FFF);
    send_request(MODE_OBS, 16'd1, -16'sd32768);
    send_request(3'd5, 16'hFFFF, 16'sh7FFF);
    send_request(3'd6, 16'd0, -16'sd32768);
    send_request(3'd7, 16'd1, 16'sd1);
    send_request(MODE_BIAS, 16'd1024, 16'sd5);
    send_request(MODE_BIAS, 16'hFFFF, 16'sd5);
    send_request(MODE_MEAN, 16'd256, 16'sd7);
    send_request(MODE_SCALE, 16'hFFFF, 16'sd7);
    send_request(MODE_OBS, 16'd2, 16'sd9);
    send_request(MODE_OBS, 16'hFFFF, 16'sd9);
    send_request(MODE_WEIGHT, 16'hFFFF, -16'sd32768);
    send_request(MODE_SCALE, 16'd0, 16'sh7FFF);
    send_request(MODE_MEAN, 16'd0, -16'sd32768);
    send_vector(2);
    send_request(MODE_SCALE, 16'd1, -16'sd32768);
    send_request(MODE_MEAN, 16'd1, 16'sh7FFF);
    send_vector(2);

    run_phase(0, 1, 0, 0, 0, 0, 3);
    wait_drained();
    hold_req = 1;
    run_phase(7, 2, 2, 1, 2, 2, 4);
    no_idle = 1;
    run_phase(3, 2, 2, 0, 0, 2, 3);
    no_idle = 0;

    wait_drained();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.expected_actions.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

FILE: mlp_policy_inference_elu.f
+incdir+rtl
rtl/mlp_pkg.sv
rtl/mlp_cell.sv
rtl/mlp_mac.sv
rtl/mlp_policy_inference_elu.sv
tb/tb_mlp_policy_inference_elu.sv
